FILE: hw/rtl/nm_pkg.sv
package nm_pkg;

    localparam int N_ELEM  = 9;
    localparam int N_ROW   = 3;
    localparam int DET_W   = 98;
    localparam int DMAG_W  = DET_W - 1;
    localparam int CMAG_W  = 64;
    localparam int Q_W     = 32;
    localparam int N_STEP  = Q_W;
    localparam int N_DIV_ST = N_STEP + 1;

    typedef logic signed [31:0]         t_elem;
    typedef logic signed [63:0]         t_cof;
    typedef logic signed [64:0]         t_plo;
    typedef logic signed [DET_W-1:0]    t_det;
    typedef logic        [DMAG_W-1:0]   t_dmag;
    typedef logic        [DET_W-1:0]    t_rem;
    typedef logic        [CMAG_W-1:0]   t_cmag;
    typedef logic        [Q_W-1:0]      t_quo;

    localparam t_quo Q_ONE     = 32'h0001_0000;
    localparam t_quo Q_LIM_POS = 32'h7FFF_FFFF;
    localparam t_quo Q_LIM_NEG = 32'h8000_0000;

    // cofactor i = m[A]*m[B] - m[C]*m[D]
    localparam logic [3:0] CF_A [N_ELEM] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
    localparam logic [3:0] CF_B [N_ELEM] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
    localparam logic [3:0] CF_C [N_ELEM] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
    localparam logic [3:0] CF_D [N_ELEM] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

    localparam logic [N_ELEM-1:0] DIAG = 9'b100_010_001;

    function automatic t_cof mul_ss(input t_elem a, input t_elem b);
        t_cof wa;
        t_cof wb;
        wa = t_cof'(a);
        wb = t_cof'(b);
        return wa * wb;
    endfunction

endpackage

FILE: hw/rtl/nm_if.sv
interface nm_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] a_r0c0;
    logic signed [31:0] a_r0c1;
    logic signed [31:0] a_r0c2;
    logic signed [31:0] a_r1c0;
    logic signed [31:0] a_r1c1;
    logic signed [31:0] a_r1c2;
    logic signed [31:0] a_r2c0;
    logic signed [31:0] a_r2c1;
    logic signed [31:0] a_r2c2;

    modport source (
        output valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
               a_r2c0, a_r2c1, a_r2c2,
        input  ready
    );
    modport sink (
        input  valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
               a_r2c0, a_r2c1, a_r2c2,
        output ready
    );
endinterface

interface nm_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] n_r0c0;
    logic signed [31:0] n_r0c1;
    logic signed [31:0] n_r0c2;
    logic signed [31:0] n_r1c0;
    logic signed [31:0] n_r1c1;
    logic signed [31:0] n_r1c2;
    logic signed [31:0] n_r2c0;
    logic signed [31:0] n_r2c1;
    logic signed [31:0] n_r2c2;
    logic singular;
    logic saturated;

    modport source (
        output valid, n_r0c0, n_r0c1, n_r0c2, n_r1c0, n_r1c1, n_r1c2,
               n_r2c0, n_r2c1, n_r2c2, singular, saturated,
        input  ready
    );
    modport sink (
        input  valid, n_r0c0, n_r0c1, n_r0c2, n_r1c0, n_r1c1, n_r1c2,
               n_r2c0, n_r2c1, n_r2c2, singular, saturated,
        output ready
    );
endinterface

FILE: hw/rtl/nm_cof.sv
module nm_cof (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  nm_pkg::t_elem     i_m [nm_pkg::N_ELEM],
    output logic              o_valid,
    output nm_pkg::t_elem     o_m [nm_pkg::N_ROW],
    output nm_pkg::t_cof      o_c [nm_pkg::N_ELEM]
);

    logic          r_v1;
    logic          r_v2;
    nm_pkg::t_cof  r_pa [nm_pkg::N_ELEM];
    nm_pkg::t_cof  r_pb [nm_pkg::N_ELEM];
    nm_pkg::t_elem r_m1 [nm_pkg::N_ROW];
    nm_pkg::t_elem r_m2 [nm_pkg::N_ROW];
    nm_pkg::t_cof  r_c  [nm_pkg::N_ELEM];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < nm_pkg::N_ELEM; i++) begin
                r_pa[i] <= nm_pkg::mul_ss(i_m[nm_pkg::CF_A[i]], i_m[nm_pkg::CF_B[i]]);
                r_pb[i] <= nm_pkg::mul_ss(i_m[nm_pkg::CF_C[i]], i_m[nm_pkg::CF_D[i]]);
                r_c[i]  <= r_pa[i] - r_pb[i];
            end
            for (int k = 0; k < nm_pkg::N_ROW; k++) begin
                r_m1[k] <= i_m[k];
                r_m2[k] <= r_m1[k];
            end
        end
    end

    assign o_valid = r_v2;
    assign o_m     = r_m2;
    assign o_c     = r_c;

endmodule

FILE: hw/rtl/nm_det.sv
module nm_det (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  nm_pkg::t_elem     i_m [nm_pkg::N_ROW],
    input  nm_pkg::t_cof      i_c [nm_pkg::N_ELEM],
    output logic              o_valid,
    output logic              o_zero,
    output nm_pkg::t_dmag     o_dmag,
    output nm_pkg::t_cmag     o_cm [nm_pkg::N_ELEM],
    output logic [nm_pkg::N_ELEM-1:0] o_qneg
);

    logic          r_v3;
    logic          r_v4;
    logic          r_v5;
    nm_pkg::t_cof  r_ph [nm_pkg::N_ROW];
    nm_pkg::t_plo  r_pl [nm_pkg::N_ROW];
    nm_pkg::t_cof  r_c3 [nm_pkg::N_ELEM];
    nm_pkg::t_cof  r_c4 [nm_pkg::N_ELEM];
    nm_pkg::t_det  r_det;
    logic          r_zero;
    nm_pkg::t_dmag r_dmag;
    nm_pkg::t_cmag r_cm [nm_pkg::N_ELEM];
    logic [nm_pkg::N_ELEM-1:0] r_qneg;
    nm_pkg::t_det  n_det;
    nm_pkg::t_det  n_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_comb begin
        n_det = '0;
        for (int k = 0; k < nm_pkg::N_ROW; k++) begin
            n_det = n_det + (nm_pkg::t_det'(r_ph[k]) <<< 32) + nm_pkg::t_det'(r_pl[k]);
        end
        n_neg = -r_det;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < nm_pkg::N_ROW; k++) begin
                r_ph[k] <= i_m[k] * $signed(i_c[k][63:32]);
                r_pl[k] <= i_m[k] * $signed({1'b0, i_c[k][31:0]});
            end
            r_c3   <= i_c;
            r_c4   <= r_c3;
            r_det  <= n_det;
            r_zero <= (r_det == '0);
            r_dmag <= r_det[nm_pkg::DET_W-1] ? n_neg[nm_pkg::DMAG_W-1:0]
                                              : r_det[nm_pkg::DMAG_W-1:0];
            for (int i = 0; i < nm_pkg::N_ELEM; i++) begin
                r_cm[i]   <= r_c4[i][63] ? nm_pkg::t_cmag'(-r_c4[i]) : nm_pkg::t_cmag'(r_c4[i]);
                r_qneg[i] <= r_c4[i][63] ^ r_det[nm_pkg::DET_W-1];
            end
        end
    end

    assign o_valid = r_v5;
    assign o_zero  = r_zero;
    assign o_dmag  = r_dmag;
    assign o_cm    = r_cm;
    assign o_qneg  = r_qneg;

endmodule

FILE: hw/rtl/nm_div.sv
module nm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic              i_zero,
    input  nm_pkg::t_dmag     i_dmag,
    input  nm_pkg::t_cmag     i_cm [nm_pkg::N_ELEM],
    input  logic [nm_pkg::N_ELEM-1:0] i_qneg,
    output logic              o_valid,
    output nm_pkg::t_quo      o_n [nm_pkg::N_ELEM],
    output logic              o_singular,
    output logic              o_saturated
);

    logic          r_v    [nm_pkg::N_DIV_ST];
    logic          r_zero [nm_pkg::N_DIV_ST];
    nm_pkg::t_dmag r_dmag [nm_pkg::N_DIV_ST];
    nm_pkg::t_rem  r_rem  [nm_pkg::N_DIV_ST][nm_pkg::N_ELEM];
    nm_pkg::t_quo  r_q    [nm_pkg::N_DIV_ST][nm_pkg::N_ELEM];
    logic [nm_pkg::N_ELEM-1:0] r_ovf  [nm_pkg::N_DIV_ST];
    logic [nm_pkg::N_ELEM-1:0] r_qneg [nm_pkg::N_DIV_ST];

    nm_pkg::t_rem  n_rem  [nm_pkg::N_STEP][nm_pkg::N_ELEM];
    logic          n_qb   [nm_pkg::N_STEP][nm_pkg::N_ELEM];

    logic          r_ov;
    nm_pkg::t_quo  r_n [nm_pkg::N_ELEM];
    logic          r_sing;
    logic          r_sat;

    nm_pkg::t_quo  n_n [nm_pkg::N_ELEM];
    logic          n_sat;

    always_comb begin
        nm_pkg::t_rem sh;
        nm_pkg::t_rem dd;
        for (int s = 0; s < nm_pkg::N_STEP; s++) begin
            for (int i = 0; i < nm_pkg::N_ELEM; i++) begin
                sh = {r_rem[s][i][nm_pkg::DET_W-2:0], 1'b0};
                dd = {1'b0, r_dmag[s]};
                n_qb[s][i]  = (sh >= dd);
                n_rem[s][i] = n_qb[s][i] ? sh - dd : sh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < nm_pkg::N_DIV_ST; s++) begin
                r_v[s] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < nm_pkg::N_DIV_ST; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_ov <= r_v[nm_pkg::N_DIV_ST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= i_zero;
            r_dmag[0] <= i_dmag;
            r_qneg[0] <= i_qneg;
            for (int i = 0; i < nm_pkg::N_ELEM; i++) begin
                r_rem[0][i] <= nm_pkg::t_rem'(i_cm[i]);
                r_q[0][i]   <= '0;
                r_ovf[0][i] <= (nm_pkg::t_dmag'(i_cm[i]) >= i_dmag);
            end
            for (int s = 1; s < nm_pkg::N_DIV_ST; s++) begin
                r_zero[s] <= r_zero[s-1];
                r_dmag[s] <= r_dmag[s-1];
                r_qneg[s] <= r_qneg[s-1];
                r_ovf[s]  <= r_ovf[s-1];
                for (int i = 0; i < nm_pkg::N_ELEM; i++) begin
                    r_rem[s][i] <= n_rem[s-1][i];
                    r_q[s][i]   <= {r_q[s-1][i][nm_pkg::Q_W-2:0], n_qb[s-1][i]};
                end
            end
        end
    end

    always_comb begin
        nm_pkg::t_quo lim;
        nm_pkg::t_quo qm;
        logic         over;
        n_sat = 1'b0;
        for (int i = 0; i < nm_pkg::N_ELEM; i++) begin
            lim  = r_qneg[nm_pkg::N_DIV_ST-1][i] ? nm_pkg::Q_LIM_NEG : nm_pkg::Q_LIM_POS;
            over = r_ovf[nm_pkg::N_DIV_ST-1][i] || (r_q[nm_pkg::N_DIV_ST-1][i] > lim);
            qm   = over ? lim : r_q[nm_pkg::N_DIV_ST-1][i];
            n_sat = n_sat | over;
            if (r_zero[nm_pkg::N_DIV_ST-1]) begin
                n_n[i] = nm_pkg::DIAG[i] ? nm_pkg::Q_ONE : '0;
            end else begin
                n_n[i] = r_qneg[nm_pkg::N_DIV_ST-1][i] ? -qm : qm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= n_n;
            r_sing <= r_zero[nm_pkg::N_DIV_ST-1];
            r_sat  <= n_sat & ~r_zero[nm_pkg::N_DIV_ST-1];
        end
    end

    assign o_valid     = r_ov;
    assign o_n         = r_n;
    assign o_singular  = r_sing;
    assign o_saturated = r_sat;

endmodule

FILE: hw/rtl/normal_matrix_3x3.sv
// Channel  Role   Handshake     Payload
// i_in     sink   valid/ready   a_r0c0 .. a_r2c2, signed Q16.16
// o_out    source valid/ready   n_r0c0 .. n_r2c2, singular, saturated
//
// One matrix enters per cycle while o_out is not stalled.
// The pipeline is made of the 32 one-bit restoring divide stages, plus
// seven stages of products, cofactors, determinant and output.
// Reset clears the valid bits only.
// A stall on o_out freezes every stage at once; nothing is dropped.
module normal_matrix_3x3 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nm_in_if.sink       i_in,
    nm_out_if.source    o_out
);

    logic                      w_en;
    nm_pkg::t_elem             w_m [nm_pkg::N_ELEM];
    logic                      w_cof_v;
    nm_pkg::t_elem             w_m0 [nm_pkg::N_ROW];
    nm_pkg::t_cof              w_c [nm_pkg::N_ELEM];
    logic                      w_det_v;
    logic                      w_zero;
    nm_pkg::t_dmag             w_dmag;
    nm_pkg::t_cmag             w_cm [nm_pkg::N_ELEM];
    logic [nm_pkg::N_ELEM-1:0] w_qneg;
    logic                      w_out_v;
    nm_pkg::t_quo              w_n [nm_pkg::N_ELEM];
    logic                      w_sing;
    logic                      w_sat;

    assign w_en       = !w_out_v || o_out.ready;
    assign i_in.ready = w_en;

    assign w_m[0] = i_in.a_r0c0;
    assign w_m[1] = i_in.a_r0c1;
    assign w_m[2] = i_in.a_r0c2;
    assign w_m[3] = i_in.a_r1c0;
    assign w_m[4] = i_in.a_r1c1;
    assign w_m[5] = i_in.a_r1c2;
    assign w_m[6] = i_in.a_r2c0;
    assign w_m[7] = i_in.a_r2c1;
    assign w_m[8] = i_in.a_r2c2;

    nm_cof u_cof (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_m     (w_m),
        .o_valid (w_cof_v),
        .o_m     (w_m0),
        .o_c     (w_c)
    );

    nm_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cof_v),
        .i_m     (w_m0),
        .i_c     (w_c),
        .o_valid (w_det_v),
        .o_zero  (w_zero),
        .o_dmag  (w_dmag),
        .o_cm    (w_cm),
        .o_qneg  (w_qneg)
    );

    nm_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_det_v),
        .i_zero      (w_zero),
        .i_dmag      (w_dmag),
        .i_cm        (w_cm),
        .i_qneg      (w_qneg),
        .o_valid     (w_out_v),
        .o_n         (w_n),
        .o_singular  (w_sing),
        .o_saturated (w_sat)
    );

    assign o_out.valid     = w_out_v;
    assign o_out.n_r0c0    = w_n[0];
    assign o_out.n_r0c1    = w_n[1];
    assign o_out.n_r0c2    = w_n[2];
    assign o_out.n_r1c0    = w_n[3];
    assign o_out.n_r1c1    = w_n[4];
    assign o_out.n_r1c2    = w_n[5];
    assign o_out.n_r2c0    = w_n[6];
    assign o_out.n_r2c1    = w_n[7];
    assign o_out.n_r2c2    = w_n[8];
    assign o_out.singular  = w_sing;
    assign o_out.saturated = w_sat;

endmodule
